@@ rtl/core/refcounted_shared_slot_table_unit_assert.svh @@
// Assertion macros used by the slot table RTL.
`ifndef REFCOUNTED_SHARED_SLOT_TABLE_UNIT_ASSERT_SVH
`define REFCOUNTED_SHARED_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RCST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`endif

@@ rtl/core/rcst_pkg.sv @@
// Types and constants shared by the slot table modules.
`default_nettype none

package rcst_pkg;

    localparam int KEY_W      = 32;
    localparam int FRAME_W    = 20;
    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;

    // Stream widths: input beat carries key and new_frame, output beat slot, frame, count.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT        = 3'd0,
        STAT_ALLOC      = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_RELEASED   = 3'd3,
        STAT_FREED      = 3'd4,
        STAT_CLOSE_MISS = 3'd5,
        STAT_BAD_KEY    = 3'd6
    } t_status;

    typedef enum logic {
        OP_OPEN  = 1'b0,
        OP_CLOSE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // One table entry as stored in the slot memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/core/rcst_slot_ram.sv @@
// Single-port-write, registered-read memory holding the slot entries.
`default_nettype none

module rcst_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire rcst_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output rcst_pkg::t_entry      o_rdata
);
    import rcst_pkg::*;

    t_entry mem [DEPTH];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/refcounted_shared_slot_table_unit.sv @@
// Reference-counted slot table: linear scan of the slot memory, then one write-back.
// An accepted request reads every slot once, one address per cycle from the slot memory;
// the result beat follows the scan, and a new request is taken only once the previous
// result has been registered. A key of zero skips the scan and goes straight to the
// finishing step. A held result beat stalls the finish; synchronous active-low reset
// clears all valid bits.
`default_nettype none

`include "refcounted_shared_slot_table_unit_assert.svh"

module refcounted_shared_slot_table_unit #(
    parameter int SLOTS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [31:0] key, [51:32] new_frame, [55:52] zero
    input  wire logic [rcst_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [0] op
    input  wire logic                                i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [5:0] slot, [25:6] frame, [41:26] count, [47:42] zero
    output logic [rcst_pkg::OUT_TDATA_W-1:0]         o_m_tdata,
    // [2:0] status
    output logic [rcst_pkg::STATUS_W-1:0]            o_m_tuser
);
    import rcst_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    t_state              r_state, n_state;
    logic                r_op;
    logic [KEY_W-1:0]    r_key;
    logic [FRAME_W-1:0]  r_nf;

    // Scan address issue and the read pipeline beside it.
    logic [AW-1:0]       r_addr;
    logic                r_issue_done;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_idx;
    logic                r_vld_q;
    t_entry              w_rdata;

    // Search results gathered during the scan.
    logic                r_hit;
    logic [AW-1:0]       r_hit_idx;
    t_entry              r_hit_ent;
    logic                r_emp;
    logic [AW-1:0]       r_emp_idx;

    logic [SLOTS-1:0]    r_valid;

    // Output register.
    logic                r_m_valid;
    t_status             r_m_status;
    logic [SLOT_OUT_W-1:0] r_m_slot;
    logic [FRAME_W-1:0]  r_m_frame;
    logic [COUNT_W-1:0]  r_m_count;

    // Outcome of the finishing step.
    logic                w_finish;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic                w_set_vld;
    logic                w_clr_vld;
    t_status             w_status;
    logic [AW-1:0]       w_idx;
    logic [FRAME_W-1:0]  w_frame;
    logic [COUNT_W-1:0]  w_count;

    logic                w_s_acc;
    logic                w_match;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_match    = r_rd_vld && r_vld_q && (w_rdata.key == r_key);

    rcst_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and the result of the finishing step.
    always_comb begin
        logic [COUNT_W-1:0] inc_cnt;
        logic [COUNT_W-1:0] dec_cnt;
        inc_cnt   = (r_hit_ent.count == COUNT_MAX) ? r_hit_ent.count
                                                    : COUNT_W'(r_hit_ent.count + 1'b1);
        dec_cnt   = COUNT_W'(r_hit_ent.count - 1'b1);
        n_state   = r_state;
        w_finish  = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_hit_idx;
        w_wdata   = r_hit_ent;
        w_set_vld = 1'b0;
        w_clr_vld = 1'b0;
        w_status  = STAT_BAD_KEY;
        w_idx     = '0;
        w_frame   = '0;
        w_count   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = (i_s_tdata[KEY_W-1:0] == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && (r_rd_idx == LAST_IDX)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                w_finish = !r_m_valid || i_m_tready;
                if (r_key == '0) begin
                    w_status = STAT_BAD_KEY;
                end else if (r_op == OP_OPEN) begin
                    if (r_hit) begin
                        w_status      = STAT_HIT;
                        w_idx         = r_hit_idx;
                        w_frame       = r_hit_ent.frame;
                        w_count       = inc_cnt;
                        w_we          = 1'b1;
                        w_wdata.count = inc_cnt;
                    end else if (r_emp) begin
                        w_status      = STAT_ALLOC;
                        w_idx         = r_emp_idx;
                        w_frame       = r_nf;
                        w_count       = COUNT_W'(1);
                        w_we          = 1'b1;
                        w_waddr       = r_emp_idx;
                        w_wdata.key   = r_key;
                        w_wdata.frame = r_nf;
                        w_wdata.count = COUNT_W'(1);
                        w_set_vld     = 1'b1;
                    end else begin
                        w_status = STAT_FULL;
                    end
                end else begin
                    if (!r_hit) begin
                        w_status = STAT_CLOSE_MISS;
                    end else if (r_hit_ent.count <= COUNT_W'(1)) begin
                        w_status  = STAT_FREED;
                        w_idx     = r_hit_idx;
                        w_frame   = r_hit_ent.frame;
                        w_clr_vld = 1'b1;
                    end else begin
                        w_status      = STAT_RELEASED;
                        w_idx         = r_hit_idx;
                        w_frame       = r_hit_ent.frame;
                        w_count       = dec_cnt;
                        w_we          = 1'b1;
                        w_wdata.count = dec_cnt;
                    end
                end
                // Nothing changes until the output register can take the result.
                if (!w_finish) begin
                    w_we      = 1'b0;
                    w_set_vld = 1'b0;
                    w_clr_vld = 1'b0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Request capture and scan address issue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN) && !r_issue_done;
            if (w_s_acc) begin
                r_issue_done <= 1'b0;
            end else if ((r_state == ST_SCAN) && (r_addr == LAST_IDX)) begin
                r_issue_done <= 1'b1;
            end
        end
        if (w_s_acc) begin
            r_op   <= i_s_tuser;
            r_key  <= i_s_tdata[KEY_W-1:0];
            r_nf   <= i_s_tdata[KEY_W +: FRAME_W];
            r_addr <= '0;
        end else if ((r_state == ST_SCAN) && !r_issue_done && (r_addr != LAST_IDX)) begin
            r_addr <= r_addr + 1'b1;
        end
        r_rd_idx <= r_addr;
        r_vld_q  <= r_valid[r_addr];
    end

    // First matching slot and first empty slot seen by the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_emp <= 1'b0;
        end else if (w_s_acc) begin
            r_hit <= 1'b0;
            r_emp <= 1'b0;
        end else if ((r_state == ST_SCAN) && r_rd_vld) begin
            if (w_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!r_vld_q && !r_emp) begin
                r_emp <= 1'b1;
            end
        end
        if ((r_state == ST_SCAN) && w_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
            r_hit_ent <= w_rdata;
        end
        if ((r_state == ST_SCAN) && r_rd_vld && !r_vld_q && !r_emp) begin
            r_emp_idx <= r_rd_idx;
        end
    end

    // Per-slot occupancy; a slot that is not valid reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_set_vld) begin
            r_valid[r_emp_idx] <= 1'b1;
        end else if (w_clr_vld) begin
            r_valid[r_hit_idx] <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_finish) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_finish) begin
            r_m_status <= w_status;
            r_m_slot   <= SLOT_OUT_W'(w_idx);
            r_m_frame  <= w_frame;
            r_m_count  <= w_count;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {{(OUT_TDATA_W - SLOT_OUT_W - FRAME_W - COUNT_W){1'b0}},
                         r_m_count, r_m_frame, r_m_slot};

    `RCST_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_s_acc, r_state != ST_IDLE)
    `RCST_ASSERT_NOW(a_write_only_on_finish, i_clk, i_rst_n, w_we,
        (r_state == ST_DONE) && (!r_m_valid || i_m_tready))
    `RCST_ASSERT_NOW(a_result_from_done, i_clk, i_rst_n, $rose(r_m_valid),
        $past(r_state) == ST_DONE)
    `RCST_ASSERT_NOW(a_hit_slot_occupied, i_clk, i_rst_n,
        (r_state == ST_DONE) && r_hit && (r_key != '0), r_valid[r_hit_idx])

endmodule

`default_nettype wire
